[hdl/csin_pkg.sv]
// Package for the CORDIC sine pipeline: shared types, widths and constants.
// Holds the elaboration-time functions that build pi, the gain and the arctangent table.
// No dependencies.
package csin_pkg;

  // Default configuration
  localparam int DEF_ITERATIONS = 32;
  localparam int DEF_DATA_WIDTH = 32;

  // Port widths: angle in Q4.28, sine in Q2.30
  localparam int IN_W  = 32;
  localparam int IN_FRAC = 28;
  localparam int OUT_W = 32;
  localparam int OUT_FRAC = 30;

  // Result width before saturation (Q4.30, holds -8 up to just under +8)
  localparam int RES_W = 34;
  localparam logic signed [RES_W-1:0] ONE_Q30 = 34'sh0_4000_0000;

  // pi * 2^62
  localparam logic [63:0] P62 = 64'hC90F_DAA2_2168_C235;

  // Gain 0.6072 = 759 / 1250
  localparam logic [63:0] GAIN_NUM = 64'd759;
  localparam logic [63:0] GAIN_DEN = 64'd1250;

  // Special angles that bypass the rotations
  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_POS,
    SP_NEG
  } csin_special_e;

  // Side information that travels with each item
  typedef struct packed {
    logic          folded;     // angle was folded by pi, negate result
    logic          first_dir;  // direction of rotation 0 (1: positive)
    csin_special_e special;
  } csin_flags_t;

  // round(P62 * 2^-sh), sh >= 1
  function automatic logic [63:0] pi_scaled(int sh);
    return (P62 + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // Restoring long division, used only for constants
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(0.6072 * 2^frac), halves up
  function automatic logic [63:0] gain_const(int frac);
    logic [63:0] rem;
    logic [63:0] q;
    rem = GAIN_NUM;
    q   = '0;
    for (int b = 0; b < frac; b++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= GAIN_DEN) begin
        rem  = rem - GAIN_DEN;
        q[0] = 1'b1;
      end
    end
    if ((rem << 1) >= GAIN_DEN) q = q + 64'd1;
    return q;
  endfunction

  // atan(2^-i) with frac fraction bits; arctangent series in Q0.63, then rounded
  function automatic logic [63:0] atan_const(int i, int frac);
    logic [63:0] v;
    logic [63:0] t;
    int          s;
    v = '0;
    if (i == 0) return pi_scaled(64 - frac);
    for (int k = 0; k < 32; k++) begin
      s = i * (2 * k + 1);
      if (s <= 63) begin
        t = udiv64((64'd1 << (63 - s)) + 64'(k), 64'(2 * k + 1));
        if (k % 2 == 1) v = v - t;
        else v = v + t;
      end
    end
    return (v + (64'd1 << (62 - frac))) >> (63 - frac);
  endfunction

endpackage

[hdl/csin_prep.sv]
// Front end of the sine pipeline: format conversion, range reduction and fold.
// Three register stages. Depends on csin_pkg.
module csin_prep #(
  parameter int DATA_WIDTH = csin_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [csin_pkg::IN_W-1:0]     angle_i,
  output logic                          valid_o,
  output csin_pkg::csin_flags_t         flags_o,
  output logic signed [DATA_WIDTH-1:0]  t_o
);
  import csin_pkg::*;

  localparam int FRAC = DATA_WIDTH - 4;
  localparam logic [63:0] PI64      = pi_scaled(62 - FRAC);
  localparam logic [63:0] TWO_PI64  = pi_scaled(61 - FRAC);
  localparam logic [63:0] HALF_PI64 = pi_scaled(63 - FRAC);
  localparam logic signed [DATA_WIDTH-1:0] PI_C      = PI64[DATA_WIDTH-1:0];
  localparam logic signed [DATA_WIDTH-1:0] TWO_PI_C  = TWO_PI64[DATA_WIDTH-1:0];
  localparam logic signed [DATA_WIDTH-1:0] HALF_PI_C = HALF_PI64[DATA_WIDTH-1:0];

  logic signed [DATA_WIDTH-1:0] a_conv;
  logic signed [DATA_WIDTH-1:0] a_d, a_q;
  logic signed [DATA_WIDTH-1:0] b_d, b_q;
  logic signed [DATA_WIDTH-1:0] t_d, t_q;
  csin_flags_t                  flags_d, flags_q;
  logic                         va_q, vb_q, vc_q;

  // Q4.28 to Q4.FRAC: pad fraction bits or drop them (floor)
  if (DATA_WIDTH >= IN_W) begin : g_widen
    assign a_conv = DATA_WIDTH'($signed(angle_i)) <<< (DATA_WIDTH - IN_W);
  end else begin : g_narrow
    assign a_conv = $signed(angle_i[IN_W-1 -: DATA_WIDTH]);
  end

  // Stage A: remove one whole turn when the angle lies beyond +-2*pi
  always_comb begin
    priority if (a_conv > TWO_PI_C) a_d = a_conv - TWO_PI_C;
    else if (a_conv < -TWO_PI_C)    a_d = a_conv + TWO_PI_C;
    else                            a_d = a_conv;
  end

  // Stage B: bring into [-pi, pi]
  always_comb begin
    priority if (a_q > PI_C) b_d = a_q - TWO_PI_C;
    else if (a_q < -PI_C)    b_d = a_q + TWO_PI_C;
    else                     b_d = a_q;
  end

  // Stage C: special angles and fold of the outer quadrants
  always_comb begin
    flags_d = '0;
    priority if (b_q == '0)       flags_d.special = SP_ZERO;
    else if (b_q == HALF_PI_C)    flags_d.special = SP_POS;
    else if (b_q == -HALF_PI_C)   flags_d.special = SP_NEG;
    else                          flags_d.special = SP_NONE;

    priority if (b_q > HALF_PI_C) begin
      t_d               = b_q - PI_C;
      flags_d.folded    = 1'b1;
      flags_d.first_dir = 1'b0;
    end else if (b_q < -HALF_PI_C) begin
      t_d               = b_q + PI_C;
      flags_d.folded    = 1'b1;
      flags_d.first_dir = 1'b1;
    end else begin
      t_d               = b_q;
      flags_d.folded    = 1'b0;
      flags_d.first_dir = (b_q > 0);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    t_q     <= t_d;
    flags_q <= flags_d;
  end

  assign valid_o = vc_q;
  assign flags_o = flags_q;
  assign t_o     = t_q;

endmodule

[hdl/csin_stage.sv]
// One CORDIC rotation step of the sine pipeline, one register stage.
// Shift-add on x and y, arctangent update of the residual. Depends on csin_pkg.
module csin_stage #(
  parameter int DATA_WIDTH = csin_pkg::DEF_DATA_WIDTH,
  parameter int IDX        = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  csin_pkg::csin_flags_t         flags_i,
  input  logic signed [DATA_WIDTH-1:0]  x_i,
  input  logic signed [DATA_WIDTH-1:0]  y_i,
  input  logic signed [DATA_WIDTH-1:0]  t_i,
  output logic                          valid_o,
  output csin_pkg::csin_flags_t         flags_o,
  output logic signed [DATA_WIDTH-1:0]  x_o,
  output logic signed [DATA_WIDTH-1:0]  y_o,
  output logic signed [DATA_WIDTH-1:0]  t_o
);
  import csin_pkg::*;

  localparam int FRAC = DATA_WIDTH - 4;
  localparam logic [63:0] ATAN64 = atan_const(IDX, FRAC);
  localparam logic signed [DATA_WIDTH-1:0] ATAN_C = ATAN64[DATA_WIDTH-1:0];

  logic                         dir;
  logic signed [DATA_WIDTH-1:0] xs, ys;
  logic signed [DATA_WIDTH-1:0] x_d, y_d, t_d;
  logic signed [DATA_WIDTH-1:0] x_q, y_q, t_q;
  csin_flags_t                  flags_q;
  logic                         valid_q;

  // Rotation direction: fixed by the front end for the first step
  assign dir = (IDX == 0) ? flags_i.first_dir : (t_i > 0);
  assign xs  = x_i >>> IDX;
  assign ys  = y_i >>> IDX;

  always_comb begin
    if (dir) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      t_d = t_i - ATAN_C;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      t_d = t_i + ATAN_C;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    t_q     <= t_d;
    flags_q <= flags_i;
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign t_o     = t_q;

endmodule

[hdl/csin_post.sv]
// Back end of the sine pipeline: round to Q2.30, undo the fold, saturate,
// and select the fixed results of special angles. Depends on csin_pkg.
module csin_post #(
  parameter int DATA_WIDTH = csin_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  csin_pkg::csin_flags_t         flags_i,
  input  logic signed [DATA_WIDTH-1:0]  y_i,
  output logic                          valid_o,
  output logic [csin_pkg::OUT_W-1:0]    sine_o
);
  import csin_pkg::*;

  localparam int FRAC = DATA_WIDTH - 4;

  logic signed [RES_W-1:0] r_scaled;
  logic signed [RES_W-1:0] r_sign;
  logic signed [RES_W-1:0] r_sat;
  logic [OUT_W-1:0]        sine_d, sine_q;
  logic                    valid_q;

  // Scale to 30 fraction bits, round half up when dropping bits
  if (FRAC > OUT_FRAC) begin : g_round
    localparam logic signed [DATA_WIDTH-1:0] HALF_LSB =
      DATA_WIDTH'(64'd1 << (FRAC - OUT_FRAC - 1));
    logic signed [DATA_WIDTH-1:0] y_rnd;
    logic signed [DATA_WIDTH-1:0] y_shr;
    assign y_rnd    = y_i + HALF_LSB;
    assign y_shr    = y_rnd >>> (FRAC - OUT_FRAC);
    assign r_scaled = RES_W'(y_shr);
  end else begin : g_pad
    assign r_scaled = RES_W'(y_i) <<< (OUT_FRAC - FRAC);
  end

  // Negate for folded angles, then clamp to +-1
  always_comb begin
    r_sign = flags_i.folded ? -r_scaled : r_scaled;
    priority if (r_sign > ONE_Q30) r_sat = ONE_Q30;
    else if (r_sign < -ONE_Q30)    r_sat = -ONE_Q30;
    else                           r_sat = r_sign;
  end

  // Special angles override the rotation result
  always_comb begin
    unique case (flags_i.special)
      SP_ZERO: sine_d = '0;
      SP_POS:  sine_d = ONE_Q30[OUT_W-1:0];
      SP_NEG:  sine_d = OUT_W'(-ONE_Q30);
      SP_NONE: sine_d = r_sat[OUT_W-1:0];
      default: sine_d = r_sat[OUT_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q <= sine_d;
  end

  assign valid_o = valid_q;
  assign sine_o  = sine_q;

endmodule

[hdl/cordic_sine.sv]
// CORDIC sine, fully pipelined: one angle accepted on every clock, busy stays low.
// Stages: 3 front-end stages, one per rotation, 1 output stage.
// Throughput: one item per cycle, with a single rotation per stage.
// Reset clears all valid bits at once; items in flight are dropped, no result follows.
// Results are shown for one cycle with done_o and cannot be held off.
module cordic_sine #(
  parameter int ITERATIONS = csin_pkg::DEF_ITERATIONS,
  parameter int DATA_WIDTH = csin_pkg::DEF_DATA_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [csin_pkg::IN_W-1:0]   angle_i,
  output logic                        done_o,
  output logic [csin_pkg::OUT_W-1:0]  sine_o
);
  import csin_pkg::*;

  localparam int FRAC    = DATA_WIDTH - 4;
  localparam int LATENCY = ITERATIONS + 4;
  localparam logic [63:0] GAIN64 = gain_const(FRAC);
  localparam logic signed [DATA_WIDTH-1:0] GAIN_C = GAIN64[DATA_WIDTH-1:0];

  logic                         valid_w [ITERATIONS+1];
  csin_flags_t                  flags_w [ITERATIONS+1];
  logic signed [DATA_WIDTH-1:0] x_w     [ITERATIONS+1];
  logic signed [DATA_WIDTH-1:0] y_w     [ITERATIONS+1];
  logic signed [DATA_WIDTH-1:0] t_w     [ITERATIONS+1];

  // Pipeline never stalls
  assign busy = 1'b0;

  // Reduction and fold
  csin_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .angle_i (angle_i),
    .valid_o (valid_w[0]),
    .flags_o (flags_w[0]),
    .t_o     (t_w[0])
  );

  // Rotation start vector
  assign x_w[0] = GAIN_C;
  assign y_w[0] = '0;

  // One stage per rotation
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    csin_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .flags_i (flags_w[i]),
      .x_i     (x_w[i]),
      .y_i     (y_w[i]),
      .t_i     (t_w[i]),
      .valid_o (valid_w[i+1]),
      .flags_o (flags_w[i+1]),
      .x_o     (x_w[i+1]),
      .y_o     (y_w[i+1]),
      .t_o     (t_w[i+1])
    );
  end

  // Rounding, sign and saturation
  csin_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_w[ITERATIONS]),
    .flags_i (flags_w[ITERATIONS]),
    .y_i     (y_w[ITERATIONS]),
    .valid_o (done_o),
    .sine_o  (sine_o)
  );

  // Every accepted item comes out after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("item accepted but no result after pipeline latency");

  // No result without an item accepted the same latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result with no matching accepted item");

  // Results lie within [-1, +1] in Q2.30
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(sine_o) <= ONE_Q30 && $signed(sine_o) >= -ONE_Q30))
    else $error("sine result outside [-1, +1]");

endmodule
